/* rtl/assert_macros.svh */
// Assertion macros of the ellipse rasterizer RTL, included by the top level.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/erb_pkg.sv */
// Package of the ellipse rasterizer: command codes, state type, walk widths.
// No dependencies; used by the sequencer, the pixel port and the top level.
`timescale 1ns / 1ps

package erb_pkg;

   // Command codes carried in tuser
   typedef enum logic [1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_PLOT    = 2'd1,
      CMD_ELLIPSE = 2'd2,
      CMD_READ    = 2'd3
   } cmd_type;

   // Outline and interior modes
   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_SET  = 2'd2;

   // Register indexes
   localparam logic CSR_WIDTH_IDX  = 1'b0;
   localparam logic CSR_HEIGHT_IDX = 1'b1;

   // Field widths
   localparam int COORD_IN_W = 7;
   localparam int COORD_W    = 10;   // signed walk coordinates
   localparam int SQ_W       = 14;   // square of a 7-bit extent
   localparam int WALK_W     = 40;   // error term and its increments
   localparam int ERR_SHIFT  = 3;    // error scale of 8
   localparam int STEP_SHIFT = 2;    // step scale of 4
   localparam int GUARD_W    = 13;
   localparam int WALK_GUARD = 4096;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PLOT,
      ST_READ,
      ST_READ_WAIT,
      ST_SETUP_MUL,
      ST_SETUP_ERR,
      ST_CORNER,
      ST_DECIDE,
      ST_FILL,
      ST_YSTEP,
      ST_XSTEP,
      ST_TAIL,
      ST_DONE
   } state_type;

   // One pixel access from the sequencer to the canvas port
   typedef struct packed {
      logic                      valid;
      logic                      write;
      logic                      clear;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      val;
   } pix_req_type;

endpackage

/* rtl/ellipse_rasterizer_bitmap.sv */
// Top level of the one-bit canvas with ellipse rasterizer.
// Depends on erb_pkg, erb_seq, erb_pix_port (and erb_ram), assert_macros.svh.
`timescale 1ns / 1ps

// The canvas is one bit per pixel in a single-port RAM of MAX_WIDTH*MAX_HEIGHT
// entries, and every command walks through that one port, one pixel per cycle when it touches pixels.
// After reset the block sweeps the RAM to zero before req_tready rises. A plot
// passes through its plot state and the done state to its result, a read through
// its read, read-wait and done states, a clear through the sweep and the done
// state. An ellipse runs the setup states (squares, then error terms), then per
// walk step the outline corners (skipped if not drawn), the decision and step
// states and, if filled, the interior columns, then the tail rows if an outline
// is drawn. The result waits in an output register; a new command is taken once
// the current one has finished.
module ellipse_rasterizer_bitmap #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128
) (
   input  logic        clock,
   input  logic        reset,
   // tdata: x_a[6:0], y_a[13:7], x_b[20:14], y_b[27:21], edge_mode[29:28],
   //        fill_mode[31:30], pixel_value[32], zero pad[39:33]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // tuser: req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: read_value[0], out_of_range[1], zero pad[7:2]
   output logic [7:0]  rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);
   import erb_pkg::*;

`include "assert_macros.svh"

   localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

   logic [7:0]        canvas_width_ff, canvas_height_ff;
   pix_req_type       pix;
   logic [ADDR_W-1:0] clr_addr;
   logic              pix_inside, rd_bit, rsp_rv, rsp_oor;

   // Size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff  <= 8'd128;
         canvas_height_ff <= 8'd128;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH_IDX:  canvas_width_ff  <= csr_wdata;
            CSR_HEIGHT_IDX: canvas_height_ff <= csr_wdata;
            default:        canvas_width_ff  <= canvas_width_ff;
         endcase
      end
   end

   erb_seq #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_read_value   (rsp_rv),
      .rsp_out_of_range (rsp_oor),
      .pix              (pix),
      .clr_addr         (clr_addr),
      .pix_inside       (pix_inside),
      .rd_bit           (rd_bit)
   );

   erb_pix_port #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_pix (
      .clock         (clock),
      .pix           (pix),
      .clr_addr      (clr_addr),
      .canvas_width  (canvas_width_ff),
      .canvas_height (canvas_height_ff),
      .pix_inside    (pix_inside),
      .rd_bit        (rd_bit)
   );

   assign rsp_tdata = {6'b000000, rsp_oor, rsp_rv};

   // A flagged read never returns a set pixel
   `ASSERT_NEVER(a_oor_reads_zero, rsp_tvalid && rsp_tdata[0] && rsp_tdata[1], "set bit with range flag")
   // One command at a time: no item is taken in the cycle after one was
   `ASSERT_CLK(a_one_cmd, req_tvalid && req_tready |=> !req_tready, "command taken while busy")
   // The clearing sweep holds off commands right after reset
   `ASSERT_ALWAYS(a_clear_after_reset, $past(reset) |-> !req_tready, "ready during clearing sweep")

endmodule

/* rtl/erb_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module erb_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read-first port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/erb_pix_port.sv */
// Canvas port: bounds check, pixel address and the bitmap memory.
// Depends on erb_pkg and erb_ram.
`timescale 1ns / 1ps

module erb_pix_port #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128
) (
   input  logic                 clock,
   input  erb_pkg::pix_req_type pix,
   input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] clr_addr,
   input  logic [7:0]           canvas_width,
   input  logic [7:0]           canvas_height,
   output logic                 pix_inside,
   output logic                 rd_bit
);
   import erb_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int WCAP   = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
   localparam int HCAP   = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;

   logic [7:0]        act_w;
   logic [7:0]        act_h;
   logic [15:0]       lin;
   logic [ADDR_W-1:0] addr;
   logic              we;

   // Active size is the register clipped to the store
   assign act_w = (canvas_width  < 8'(WCAP)) ? canvas_width  : 8'(WCAP);
   assign act_h = (canvas_height < 8'(HCAP)) ? canvas_height : 8'(HCAP);

   assign pix_inside = (pix.x >= 0) && (pix.y >= 0)
                    && ($signed({{(COORD_W-8){1'b0}}, act_w}) > pix.x)
                    && ($signed({{(COORD_W-8){1'b0}}, act_h}) > pix.y);

   // Row-major address, row stride is the active width
   assign lin = 16'(pix.y[7:0] * act_w) + 16'(pix.x[7:0]);

   always_comb begin
      if (pix.clear) begin
         addr = clr_addr;
         we   = 1'b1;
      end else begin
         addr = ADDR_W'(lin);
         we   = pix.valid && pix.write && pix_inside;
      end
   end

   erb_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_canvas (
      .clock (clock),
      .we    (we),
      .addr  (addr),
      .wdata (pix.val && !pix.clear),
      .rdata (rd_bit)
   );

endmodule

/* rtl/erb_seq.sv */
// Command sequencer: clearing sweep, plot, read and the midpoint ellipse walk.
// Depends on erb_pkg; drives the canvas port at most one pixel per cycle.
`timescale 1ns / 1ps

module erb_seq #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [39:0]          req_tdata,
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic                 rsp_read_value,
   output logic                 rsp_out_of_range,
   output erb_pkg::pix_req_type pix,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] clr_addr,
   input  logic                 pix_inside,
   input  logic                 rd_bit
);
   import erb_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef logic signed [COORD_W-1:0] crd_type;
   typedef logic signed [WALK_W-1:0]  walk_type;

   state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic clr_cmd_ff, clr_cmd_in;
   logic [1:0] edge_ff, edge_in, fill_ff, fill_in, sub_ff, sub_in;
   logic pv_ff, pv_in, oor_ff, oor_in, rv_ff, rv_in;
   crd_type x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in, xr_ff, xr_in;
   logic [COORD_IN_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [SQ_W-1:0] asq_ff, asq_in, bsq_ff, bsq_in;
   walk_type dx_ff, dx_in, dy_ff, dy_in, err_ff, err_in, e2_ff, e2_in;
   logic [GUARD_W-1:0] guard_ff, guard_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_rv_ff, rsp_rv_in, rsp_oor_ff, rsp_oor_in;

   // Input fields
   logic [COORD_IN_W-1:0] f_xa, f_ya, f_xb, f_yb, lo_x, hi_x, lo_y;
   logic [1:0] f_edge, f_fill;
   logic       f_pv;

   // Walk helpers
   logic signed [8:0]  one_m_a;
   logic signed [23:0] mul_dx;
   walk_type a_inc, b_inc, dx_c, dy_c, e2_c, err2_c;
   logic     bodd, xcond, ev, fv;
   crd_type  x0_n, x1_n, ydiff;

   assign f_xa   = req_tdata[6:0];
   assign f_ya   = req_tdata[13:7];
   assign f_xb   = req_tdata[20:14];
   assign f_yb   = req_tdata[27:21];
   assign f_edge = req_tdata[29:28];
   assign f_fill = req_tdata[31:30];
   assign f_pv   = req_tdata[32];

   assign lo_x = (f_xa < f_xb) ? f_xa : f_xb;
   assign hi_x = (f_xa < f_xb) ? f_xb : f_xa;
   assign lo_y = (f_ya < f_yb) ? f_ya : f_yb;

   assign bodd    = b_ff[0];
   assign a_inc   = WALK_W'({asq_ff, {ERR_SHIFT{1'b0}}});
   assign b_inc   = WALK_W'({bsq_ff, {ERR_SHIFT{1'b0}}});
   assign one_m_a = 9'sd1 - $signed({2'b00, a_ff});
   assign mul_dx  = one_m_a * $signed({1'b0, bsq_ff});
   assign dx_c    = WALK_W'(mul_dx) <<< STEP_SHIFT;
   assign dy_c    = bodd ? WALK_W'({asq_ff, 3'b000}) : WALK_W'({asq_ff, 2'b00});
   assign e2_c    = err_ff <<< 1;
   assign err2_c  = err_ff <<< 1;
   assign xcond   = (e2_ff >= dx_ff) || (err2_c > dy_ff);
   assign x0_n    = xcond ? x0_ff + crd_type'(1) : x0_ff;
   assign x1_n    = xcond ? x1_ff - crd_type'(1) : x1_ff;
   assign ydiff   = y0_ff - y1_ff;
   assign ev      = (edge_ff == MODE_SET);
   assign fv      = (fill_ff == MODE_SET);

   // State and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_cmd_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dx_ff        <= '0;
         dy_ff        <= '0;
         err_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_cmd_ff   <= clr_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
         dx_ff        <= dx_in;
         dy_ff        <= dy_in;
         err_ff       <= err_in;
      end
      edge_ff    <= edge_in;
      fill_ff    <= fill_in;
      sub_ff     <= sub_in;
      pv_ff      <= pv_in;
      oor_ff     <= oor_in;
      rv_ff      <= rv_in;
      x0_ff      <= x0_in;
      x1_ff      <= x1_in;
      y0_ff      <= y0_in;
      y1_ff      <= y1_in;
      xr_ff      <= xr_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      asq_ff     <= asq_in;
      bsq_ff     <= bsq_in;
      e2_ff      <= e2_in;
      guard_ff   <= guard_in;
      rsp_rv_ff  <= rsp_rv_in;
      rsp_oor_ff <= rsp_oor_in;
   end

   // Next state, walk arithmetic and pixel requests
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      clr_cmd_in   = clr_cmd_ff;
      edge_in      = edge_ff;
      fill_in      = fill_ff;
      sub_in       = sub_ff;
      pv_in        = pv_ff;
      oor_in       = oor_ff;
      rv_in        = rv_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      xr_in        = xr_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      asq_in       = asq_ff;
      bsq_in       = bsq_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      err_in       = err_ff;
      e2_in        = e2_ff;
      guard_in     = guard_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_rv_in    = rsp_rv_ff;
      rsp_oor_in   = rsp_oor_ff;
      req_tready   = 1'b0;
      pix          = '0;

      case (state_ff)
         ST_CLEAR: begin
            pix.clear   = 1'b1;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               clr_addr_in = '0;
               state_in    = clr_cmd_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               oor_in  = 1'b0;
               rv_in   = 1'b0;
               edge_in = f_edge;
               fill_in = f_fill;
               pv_in   = f_pv;
               case (cmd_type'(req_tuser))
                  CMD_CLEAR: begin
                     clr_cmd_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  CMD_PLOT: begin
                     x0_in    = crd_type'(f_xa);
                     y0_in    = crd_type'(f_ya);
                     state_in = ST_PLOT;
                  end
                  CMD_ELLIPSE: begin
                     a_in     = hi_x - lo_x;
                     b_in     = (f_ya > f_yb) ? f_ya - f_yb : f_yb - f_ya;
                     x0_in    = crd_type'(lo_x);
                     x1_in    = crd_type'(hi_x);
                     y0_in    = crd_type'(lo_y) + crd_type'((b_in + 8'd1) >> 1);
                     y1_in    = y0_in - crd_type'(b_in[0]);
                     state_in = ST_SETUP_MUL;
                  end
                  CMD_READ: begin
                     x0_in    = crd_type'(f_xa);
                     y0_in    = crd_type'(f_ya);
                     state_in = ST_READ;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_PLOT: begin
            pix.valid = 1'b1;
            pix.write = 1'b1;
            pix.x     = x0_ff;
            pix.y     = y0_ff;
            pix.val   = pv_ff;
            oor_in    = !pix_inside;
            state_in  = ST_DONE;
         end
         ST_READ: begin
            pix.valid = 1'b1;
            pix.x     = x0_ff;
            pix.y     = y0_ff;
            oor_in    = !pix_inside;
            state_in  = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            rv_in    = rd_bit && !oor_ff;
            state_in = ST_DONE;
         end
         ST_SETUP_MUL: begin
            asq_in   = a_ff * a_ff;
            bsq_in   = b_ff * b_ff;
            state_in = ST_SETUP_ERR;
         end
         ST_SETUP_ERR: begin
            dx_in    = dx_c;
            dy_in    = dy_c;
            err_in   = dx_c + dy_c + (bodd ? WALK_W'(asq_ff) : '0);
            guard_in = '0;
            sub_in   = '0;
            state_in = ST_CORNER;
         end
         // Four outline pixels of the current step, skipped when the edge mode is none
         ST_CORNER: begin
            if (edge_ff == MODE_NONE) begin
               state_in = ST_DECIDE;
            end else begin
               pix.valid = 1'b1;
               pix.write = 1'b1;
               pix.val   = ev;
               pix.x     = (sub_ff == 2'd0 || sub_ff == 2'd3) ? x1_ff : x0_ff;
               pix.y     = sub_ff[1] ? y1_ff : y0_ff;
               sub_in    = sub_ff + 2'd1;
               if (sub_ff == 2'd3) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            e2_in = e2_c;
            if (e2_c <= dy_ff) begin
               xr_in    = x0_ff + crd_type'(1);
               sub_in   = '0;
               state_in = (fill_ff != MODE_NONE) ? ST_FILL : ST_YSTEP;
            end else begin
               state_in = ST_XSTEP;
            end
         end
         // Interior span on both rows, one pixel a cycle
         ST_FILL: begin
            if (xr_ff < x1_ff) begin
               pix.valid = 1'b1;
               pix.write = 1'b1;
               pix.val   = fv;
               pix.x     = xr_ff;
               pix.y     = sub_ff[0] ? y1_ff : y0_ff;
               sub_in    = {1'b0, !sub_ff[0]};
               if (sub_ff[0]) begin
                  xr_in = xr_ff + crd_type'(1);
               end
            end else begin
               state_in = ST_YSTEP;
            end
         end
         ST_YSTEP: begin
            y0_in    = y0_ff + crd_type'(1);
            y1_in    = y1_ff - crd_type'(1);
            dy_in    = dy_ff + a_inc;
            err_in   = err_ff + dy_ff + a_inc;
            state_in = ST_XSTEP;
         end
         ST_XSTEP: begin
            x0_in    = x0_n;
            x1_in    = x1_n;
            guard_in = guard_ff + GUARD_W'(1);
            sub_in   = '0;
            if (xcond) begin
               dx_in  = dx_ff + b_inc;
               err_in = err_ff + dx_ff + b_inc;
            end
            if (x0_n <= x1_n && guard_ff < GUARD_W'(WALK_GUARD - 1)) begin
               state_in = ST_CORNER;
            end else begin
               state_in = (edge_ff == MODE_NONE) ? ST_DONE : ST_TAIL;
            end
         end
         // Flat-ellipse tail: side pixels just outside the last span
         ST_TAIL: begin
            pix.write = 1'b1;
            pix.val   = ev;
            pix.x     = sub_ff[0] ? x1_ff + crd_type'(1) : x0_ff - crd_type'(1);
            pix.y     = sub_ff[1] ? y1_ff : y0_ff;
            sub_in    = sub_ff + 2'd1;
            case (sub_ff)
               2'd0: begin
                  if (ydiff < $signed({3'b000, b_ff})) begin
                     pix.valid = 1'b1;
                  end else begin
                     sub_in   = '0;
                     state_in = ST_DONE;
                  end
               end
               2'd1: begin
                  pix.valid = 1'b1;
                  y0_in     = y0_ff + crd_type'(1);
               end
               2'd2: pix.valid = 1'b1;
               2'd3: begin
                  pix.valid = 1'b1;
                  y1_in     = y1_ff - crd_type'(1);
               end
               default: sub_in = '0;
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_rv_in    = rv_ff;
               rsp_oor_in   = oor_ff;
               clr_cmd_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign clr_addr         = clr_addr_ff;
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_read_value   = rsp_rv_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

/* verif/ellipse_rasterizer_bitmap_checker.sv */
// Checker for the ellipse rasterizer: watches the command and result channels,
// keeps its own canvas and predicts each result. Depends on erb_pkg.
`timescale 1ns / 1ps

module ellipse_rasterizer_bitmap_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata,
   output int          fail_count,
   output int          pending_count
);
   import erb_pkg::*;

   localparam int CANVAS_W = 128;
   localparam int CANVAS_H = 128;

   typedef struct packed {
      logic read_value;
      logic out_of_range;
   } pixel_result_t;

   logic          canvas [CANVAS_W*CANVAS_H];
   logic [7:0]    width_reg;
   logic [7:0]    height_reg;
   pixel_result_t expected_results [$];

   function automatic int active_w();
      return (width_reg < CANVAS_W) ? int'(width_reg) : CANVAS_W;
   endfunction

   function automatic int active_h();
      return (height_reg < CANVAS_H) ? int'(height_reg) : CANVAS_H;
   endfunction

   function automatic bit on_canvas(int x, int y);
      return x >= 0 && y >= 0 && x < active_w() && y < active_h();
   endfunction

   task automatic set_pixel(int x, int y, logic v);
      if (on_canvas(x, y)) canvas[y*active_w() + x] = v;
   endtask

   // Midpoint ellipse walk inside the box, outline and interior spans
   task automatic rasterize(int x0, int y0, int x1, int y1, logic [1:0] edge_m,
                            logic [1:0] fill_m);
      longint a, b, b_odd, a_inc, b_inc, dx, dy, err, e2;
      logic ev, fv;
      int steps, xr;
      a = (x1 > x0) ? x1 - x0 : x0 - x1;
      b = (y1 > y0) ? y1 - y0 : y0 - y1;
      b_odd = b & 1;
      a_inc = 8*a*a;
      b_inc = 8*b*b;
      dx = 4*(1 - a)*b*b;
      dy = 4*(b_odd + 1)*a*a;
      err = dx + dy + b_odd*a*a;
      ev = (edge_m == MODE_SET);
      fv = (fill_m == MODE_SET);
      steps = 0;
      if (x0 > x1) begin
         xr = x0; x0 = x1; x1 = xr;
      end
      if (y0 > y1) y0 = y1;
      y0 += int'((b + 1) / 2);
      y1 = y0 - int'(b_odd);
      do begin
         if (edge_m != MODE_NONE) begin
            set_pixel(x1, y0, ev);
            set_pixel(x0, y0, ev);
            set_pixel(x0, y1, ev);
            set_pixel(x1, y1, ev);
         end
         e2 = 2*err;
         if (e2 <= dy) begin
            if (fill_m != MODE_NONE)
               for (xr = x0 + 1; xr < x1; xr++) begin
                  set_pixel(xr, y0, fv);
                  set_pixel(xr, y1, fv);
               end
            y0++; y1--;
            dy += a_inc;
            err += dy;
         end
         if (e2 >= dx || 2*err > dy) begin
            x0++; x1--;
            dx += b_inc;
            err += dx;
         end
         steps++;
      end while (x0 <= x1 && steps < 4096);
      // flat ellipses: finish the outline rows
      if (edge_m != MODE_NONE)
         while (longint'(y0) - longint'(y1) < b) begin
            set_pixel(x0 - 1, y0, ev);
            set_pixel(x1 + 1, y0, ev);
            y0++;
            set_pixel(x0 - 1, y1, ev);
            set_pixel(x1 + 1, y1, ev);
            y1--;
         end
   endtask

   task automatic apply_command(logic [1:0] kind, logic [39:0] d);
      pixel_result_t r;
      int xa, ya;
      xa = d[6:0];
      ya = d[13:7];
      r = '0;
      case (cmd_type'(kind))
         CMD_CLEAR:   foreach (canvas[i]) canvas[i] = 1'b0;
         CMD_PLOT:    if (on_canvas(xa, ya)) canvas[ya*active_w() + xa] = d[32];
                      else r.out_of_range = 1'b1;
         CMD_ELLIPSE: rasterize(xa, ya, d[20:14], d[27:21], d[29:28], d[31:30]);
         default:     if (on_canvas(xa, ya)) r.read_value = canvas[ya*active_w() + xa];
                      else r.out_of_range = 1'b1;
      endcase
      expected_results.push_back(r);
   endtask

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      pixel_result_t want;
      if (reset) begin
         foreach (canvas[i]) canvas[i] = 1'b0;
         width_reg = 8'd128;
         height_reg = 8'd128;
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result item %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[0] !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d", want.read_value, rsp_tdata[0]);
                  fail_count++;
               end
               if (rsp_tdata[1] !== want.out_of_range) begin
                  $error("out_of_range: expected %0d, got %0d", want.out_of_range,
                         rsp_tdata[1]);
                  fail_count++;
               end
               if (rsp_tdata[7:2] !== 6'd0) begin
                  $error("pad: expected 0, got %h", rsp_tdata[7:2]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) apply_command(req_tuser, req_tdata);
         if (csr_we) begin
            if (csr_index == CSR_WIDTH_IDX) width_reg = csr_wdata;
            else height_reg = csr_wdata;
         end
      end
   end
endmodule

/* verif/ellipse_rasterizer_bitmap_tb.sv */
// Top of the ellipse rasterizer testbench: clock, reset, commands, result stalls
// and verdict. Depends on erb_pkg, the block and ellipse_rasterizer_bitmap_checker.
`timescale 1ns / 1ps

module ellipse_rasterizer_bitmap_tb;
   import erb_pkg::*;

   localparam longint CYCLE_LIMIT = 10_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = CMD_CLEAR;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_WIDTH_IDX;
   logic [7:0]  csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   longint      cycle_count = 0;

   always #10 clock = ~clock;

   ellipse_rasterizer_bitmap uut (.*);

   ellipse_rasterizer_bitmap_checker checker_i (.*);

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ellipse_rasterizer_bitmap_tb: done, errors");
         $finish;
      end
   end

   // Result side stalls, with stretches of none
   initial begin
      int gap;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(20, 60)) @(negedge clock);
         end
         gap = $urandom_range(0, 14);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Valid stays up after an accept until the next negedge decides: new item or gap
   task automatic send_item(cmd_type kind, logic [6:0] xa, logic [6:0] ya, logic [6:0] xb,
                            logic [6:0] yb, logic [1:0] em, logic [1:0] fm, logic pv,
                            bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'd0, pv, fm, em, yb, xb, ya, xa};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [7:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Small boxes mostly, the occasional large one
   task automatic random_item();
      cmd_type k;
      logic [6:0] xa, ya, xb, yb;
      int span;
      k = cmd_type'($urandom_range(0, 3));
      if ($urandom_range(0, 15) == 0) k = CMD_CLEAR;
      else if (k == CMD_CLEAR) k = CMD_ELLIPSE;
      span = ($urandom_range(0, 9) == 0) ? 127 : 20;
      xa = 7'($urandom_range(0, 127));
      ya = 7'($urandom_range(0, 127));
      xb = 7'((int'(xa) + $urandom_range(0, span)) % 128);
      yb = 7'((int'(ya) + $urandom_range(0, span)) % 128);
      if ($urandom_range(0, 1)) begin
         xa ^= xb; xb ^= xa; xa ^= xb;
      end
      send_item(k, xa, ya, xb, yb, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
   endtask

   initial begin
      logic [7:0] widths [5];
      logic [7:0] heights [5];
      widths = '{8'd128, 8'd1, 8'd255, 8'd0, 8'd37};
      heights = '{8'd128, 8'd200, 8'd1, 8'd64, 8'd0};
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, every command, flat and degenerate ellipses
      send_item(CMD_PLOT, 0, 0, 0, 0, 0, 0, 1);
      send_item(CMD_PLOT, 127, 127, 0, 0, 0, 0, 1);
      send_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0);
      send_item(CMD_READ, 127, 127, 0, 0, 0, 0, 0);
      send_item(CMD_ELLIPSE, 10, 10, 30, 20, 2, 2, 0);
      send_item(CMD_READ, 20, 15, 0, 0, 0, 0, 0);
      send_item(CMD_ELLIPSE, 12, 12, 28, 18, 1, 3, 0);
      send_item(CMD_READ, 20, 15, 0, 0, 0, 0, 0);
      send_item(CMD_ELLIPSE, 40, 5, 42, 60, 2, 0, 0);
      send_item(CMD_ELLIPSE, 50, 70, 90, 70, 3, 2, 0);
      send_item(CMD_ELLIPSE, 5, 5, 5, 5, 2, 2, 0);
      send_item(CMD_ELLIPSE, 100, 100, 127, 127, 2, 1, 1);
      send_item(CMD_ELLIPSE, 127, 127, 0, 0, 2, 2, 1);
      send_item(CMD_READ, 64, 64, 0, 0, 0, 0, 0);
      send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      send_item(CMD_READ, 64, 64, 0, 0, 0, 0, 0);

      // Random phases over several canvas sizes, extremes included
      foreach (widths[p]) begin
         wait_idle();
         write_reg(CSR_WIDTH_IDX, widths[p]);
         write_reg(CSR_HEIGHT_IDX, heights[p]);
         send_item(CMD_ELLIPSE, 0, 0, 127, 127, 2, 2, 0);
         send_item(CMD_READ, 127, 0, 0, 0, 0, 0, 0);
         repeat (17) random_item();
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("ellipse_rasterizer_bitmap_tb: done, clean");
      end else begin
         $display("ellipse_rasterizer_bitmap_tb: done, errors");
      end
      $finish;
   end
endmodule
